// ===== design/bdq_pkg.sv =====
// Shared types and codes for the bounded deque unit.
// Used by bdq_front, bdq_back and the top level; depends on nothing else.
package bdq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned KindWidth  = 4;

  // Request kinds as they arrive on the input port.
  localparam logic [KindWidth-1:0] KIND_PUSH_FRONT = 4'd0;
  localparam logic [KindWidth-1:0] KIND_PUSH_BACK  = 4'd1;
  localparam logic [KindWidth-1:0] KIND_POP_FRONT  = 4'd2;
  localparam logic [KindWidth-1:0] KIND_POP_BACK   = 4'd3;
  localparam logic [KindWidth-1:0] KIND_CLEAR      = 4'd4;
  localparam logic [KindWidth-1:0] KIND_REMOVE     = 4'd5;
  localparam logic [KindWidth-1:0] KIND_EMIT_ALL   = 4'd6;
  localparam logic [KindWidth-1:0] KIND_EMIT_FIRST = 4'd7;
  localparam logic [KindWidth-1:0] KIND_EMIT_LAST  = 4'd8;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_CLEAR,
    OP_REMOVE,
    OP_EMIT_ALL,
    OP_EMIT_FIRST,
    OP_EMIT_LAST,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    op_e                          op;
    logic signed [ValueWidth-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         has_element;
    status_e                      status;
    logic                         last;
  } res_t;

endpackage

// ===== design/bdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bdq_front.sv =====
// Front end of the deque unit: takes request items, decodes them and queues them.
// Depends on bdq_pkg.
module bdq_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [bdq_pkg::KindWidth-1:0]           kind_i,
  input  logic signed [bdq_pkg::ValueWidth-1:0]   operand_i,
  output logic                                    cmd_valid_o,
  output bdq_pkg::cmd_t                           cmd_o,
  input  logic                                    cmd_pop_i
);

  bdq_pkg::cmd_t buf_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q, fill_d;
  logic          accept, pop;
  bdq_pkg::op_e  op_dec;

  always_comb begin
    unique case (kind_i)
      bdq_pkg::KIND_PUSH_FRONT: op_dec = bdq_pkg::OP_PUSH_FRONT;
      bdq_pkg::KIND_PUSH_BACK:  op_dec = bdq_pkg::OP_PUSH_BACK;
      bdq_pkg::KIND_POP_FRONT:  op_dec = bdq_pkg::OP_POP_FRONT;
      bdq_pkg::KIND_POP_BACK:   op_dec = bdq_pkg::OP_POP_BACK;
      bdq_pkg::KIND_CLEAR:      op_dec = bdq_pkg::OP_CLEAR;
      bdq_pkg::KIND_REMOVE:     op_dec = bdq_pkg::OP_REMOVE;
      bdq_pkg::KIND_EMIT_ALL:   op_dec = bdq_pkg::OP_EMIT_ALL;
      bdq_pkg::KIND_EMIT_FIRST: op_dec = bdq_pkg::OP_EMIT_FIRST;
      bdq_pkg::KIND_EMIT_LAST:  op_dec = bdq_pkg::OP_EMIT_LAST;
      default:                  op_dec = bdq_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    fill_d = fill_q;
    if (accept && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !accept) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[wr_ptr_q] <= '{op: op_dec, operand: operand_i};
    end
  end

endmodule

// ===== design/bdq_back.sv =====
// Back end of the deque unit: ring pointers, entry RAM, sequencer and result register.
// Depends on bdq_pkg and bdq_ram.
module bdq_back #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  input  bdq_pkg::cmd_t                         cmd_i,
  output logic                                  cmd_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bdq_pkg::res_t                         res_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);
  localparam logic [CW:0]   DepthWide = (CW + 1)'(DEPTH);
  localparam logic [IW-1:0] LastSlot  = IW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  function automatic logic [IW-1:0] slot_of(logic [IW-1:0] base, logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, pos};
    if (sum >= DepthWide) begin
      sum = sum - DepthWide;
    end
    return sum[IW-1:0];
  endfunction

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] end_q, end_d;
  logic [CW-1:0] cmp_pos_q, cmp_pos_d;
  logic          cmp_v_q, cmp_v_d;
  logic          found_q, found_d;
  logic signed [bdq_pkg::ValueWidth-1:0] opnd_q, opnd_d;

  logic          out_valid_q;
  bdq_pkg::res_t res_q, res_d;
  logic          out_free, out_load;

  logic                           ram_we, ram_re;
  logic [IW-1:0]                  ram_waddr, ram_raddr;
  logic [bdq_pkg::ValueWidth-1:0] ram_wdata, ram_rdata;

  logic [IW-1:0] front_prev, front_next;
  logic [CW-1:0] n_clamp, emit_n, emit_start;

  bdq_ram #(
    .WIDTH (bdq_pkg::ValueWidth),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign front_prev = (front_q == '0) ? LastSlot : front_q - IW'(1);
  assign front_next = (front_q == LastSlot) ? '0 : front_q + IW'(1);

  // Clamp of the requested count: negative is zero, beyond the fill is the fill.
  always_comb begin
    if (cmd_i.operand[bdq_pkg::ValueWidth-1]) begin
      n_clamp = '0;
    end else if (cmd_i.operand[bdq_pkg::ValueWidth-2:0] > (bdq_pkg::ValueWidth - 1)'(count_q)) begin
      n_clamp = count_q;
    end else begin
      n_clamp = cmd_i.operand[CW-1:0];
    end
    emit_n     = (cmd_i.op == bdq_pkg::OP_EMIT_ALL) ? count_q : n_clamp;
    emit_start = (cmd_i.op == bdq_pkg::OP_EMIT_LAST) ? count_q - n_clamp : '0;
  end

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    pos_d     = pos_q;
    end_d     = end_q;
    cmp_pos_d = cmp_pos_q;
    cmp_v_d   = cmp_v_q;
    found_d   = found_q;
    opnd_d    = opnd_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = front_q;
    ram_wdata = cmd_i.operand;
    ram_re    = 1'b0;
    ram_raddr = front_q;
    out_load  = 1'b0;
    res_d     = '{value: '0, has_element: 1'b0, status: bdq_pkg::ST_OK, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          opnd_d    = cmd_i.operand;
          unique case (cmd_i.op)
            bdq_pkg::OP_PUSH_FRONT: begin
              out_load = 1'b1;
              if (count_q == FullCount) begin
                res_d.status = bdq_pkg::ST_FULL;
              end else begin
                front_d   = front_prev;
                ram_we    = 1'b1;
                ram_waddr = front_prev;
                count_d   = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_PUSH_BACK: begin
              out_load = 1'b1;
              if (count_q == FullCount) begin
                res_d.status = bdq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_q, count_q);
                count_d   = count_q + CW'(1);
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                res_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                front_d = front_next;
                count_d = count_q - CW'(1);
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                res_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            bdq_pkg::OP_CLEAR: begin
              out_load = 1'b1;
              front_d  = '0;
              count_d  = '0;
            end
            bdq_pkg::OP_REMOVE: begin
              state_d = S_REMOVE;
              pos_d   = '0;
              cmp_v_d = 1'b0;
              found_d = 1'b0;
            end
            bdq_pkg::OP_EMIT_ALL, bdq_pkg::OP_EMIT_FIRST, bdq_pkg::OP_EMIT_LAST: begin
              if (emit_n == '0) begin
                out_load     = 1'b1;
                res_d.status = (count_q == '0) ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot_of(front_q, emit_start);
                pos_d     = emit_start;
                end_d     = emit_start + emit_n - CW'(1);
                state_d   = S_EMIT;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      S_REMOVE: begin
        // One read per cycle walks from the front; after a match every later
        // entry is written back one place nearer the front.
        cmp_v_d   = (pos_q != count_q);
        cmp_pos_d = pos_q;
        if (pos_q != count_q) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(front_q, pos_q);
          pos_d     = pos_q + CW'(1);
        end
        if (cmp_v_q) begin
          if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(front_q, cmp_pos_q - CW'(1));
            ram_wdata = ram_rdata;
          end else if (ram_rdata == opnd_q) begin
            found_d = 1'b1;
          end
        end
        if (!cmp_v_q && (pos_q == count_q) && out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (count_q == '0) begin
            res_d.status = bdq_pkg::ST_EMPTY;
          end else if (found_q) begin
            count_d = count_q - CW'(1);
          end else begin
            res_d.status = bdq_pkg::ST_NOTFOUND;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          res_d.value       = ram_rdata;
          res_d.has_element = 1'b1;
          res_d.last        = (pos_q == end_q);
          if (pos_q == end_q) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = slot_of(front_q, pos_q + CW'(1));
            pos_d     = pos_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      cmp_v_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      cmp_v_q <= cmp_v_d;
      found_q <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    end_q     <= end_d;
    cmp_pos_q <= cmp_pos_d;
    opnd_q    <= opnd_d;
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // Streaming only starts with at least one live entry.
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (count_q != '0))
    else $error("emit sequence running on an empty deque");

  // The store is never written while entries are being streamed out.
  a_emit_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !ram_we)
    else $error("entry store written during emit");

  // The removal walk never runs past the live entries.
  a_remove_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REMOVE) |-> (pos_q <= count_q))
    else $error("removal walk beyond fill level");

  // Only the emit sequence produces results that carry an entry.
  a_element_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_d.has_element) |-> (state_q == S_EMIT))
    else $error("entry result outside emit sequence");

  // A request is only taken while the result register can accept its result.
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (out_free && (state_q == S_IDLE)))
    else $error("request taken while busy");

endmodule

// ===== design/bounded_deque_with_remove_unit.sv =====
// Bounded deque unit: push, pop, clear, remove-by-value and emit over a ring store.
// A push, pop, clear or unknown request loads its result register when the back end takes it;
// a remove walks every live entry before it gives its result; an emit streams
// n entries, one a cycle while the consumer does not stall. All work goes through the
// single RAM read port, so the back end takes a new request only once the last one is done.
// Reset (asynchronous, active low) empties the deque; the entry RAM itself is not cleared.
module bounded_deque_with_remove_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Request channel.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [bdq_pkg::KindWidth-1:0]         kind_i,
  input  logic signed [bdq_pkg::ValueWidth-1:0] operand_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bdq_pkg::ValueWidth-1:0] element_value_o,
  output logic                                  has_element_o,
  output logic [1:0]                            status_o,
  output logic                                  last_o
);

  // The front end decodes each request item and parks it in a two-entry
  // queue, so the requester is held up only once both entries are taken while
  // the back end is busy walking the store for a removal or streaming entries out.
  logic          cmd_valid;
  logic          cmd_pop;
  bdq_pkg::cmd_t cmd;
  bdq_pkg::res_t res;

  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .operand_i   (operand_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end owns the ring pointers and the entry RAM. Each queued
  // request is executed in order; the result register at its output lets
  // the consumer stall without losing an item.
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // The result struct is unpacked onto the individual payload ports.
  assign element_value_o = res.value;
  assign has_element_o   = res.has_element;
  assign status_o        = res.status;
  assign last_o          = res.last;

endmodule
